### src/sorted_multi_timer_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted multi-timer scheduler assertion macros
// Concurrent assertion forms for the scheduler datapath.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTI_TIMER_SCHEDULER_UNIT_ASSERT_SVH
`define SORTED_MULTI_TIMER_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define SMTS_ASSERT_IMM(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smts assertion failed");

// next-cycle implication
`define SMTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smts assertion failed");

`endif

### src/smts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted multi-timer scheduler package
// Item types, codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package smts_pkg;

   localparam int TIMER_COUNT = 16;
   localparam int TIME_BITS   = 48;
   localparam int ID_W        = 4;
   localparam int IVAL_W      = 31;
   localparam int RANK_W      = $clog2(TIMER_COUNT);
   localparam int CNT_W       = $clog2(TIMER_COUNT + 1);

   localparam logic [1:0] OP_CONFIGURE = 2'd0;
   localparam logic [1:0] OP_PROCESS   = 2'd1;
   localparam logic [1:0] OP_QUERY     = 2'd2;

   localparam logic [1:0] EN_ARM    = 2'd1;
   localparam logic [1:0] EN_DISARM = 2'd2;

   localparam logic [1:0] RP_PERIODIC = 2'd1;
   localparam logic [1:0] RP_ONESHOT  = 2'd2;

   localparam logic [1:0] KIND_CONFIG = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_WAIT   = 2'd2;

   typedef struct packed {
      logic [1:0]           op;
      logic [ID_W-1:0]      timer_id;
      logic [TIME_BITS-1:0] now;
      logic [1:0]           enable_code;
      logic [1:0]           repeat_code;
      logic [IVAL_W-1:0]    interval;
      logic [IVAL_W-1:0]    first_delay;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              status;
      logic [ID_W-1:0]   fired_id;
      logic              fired;
      logic              wait_valid;
      logic [IVAL_W-1:0] wait_ms;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CFG_UPD,
      ST_UNLINK,
      ST_WHEN,
      ST_LINK_SCAN,
      ST_LINK,
      ST_DUE_SCAN,
      ST_SELECT,
      ST_QUERY_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SCAN_DUE,
      SCAN_POS,
      SCAN_HEAD
   } scan_type;

   typedef struct packed {
      logic     load;
      logic     cfg_update;
      logic     unlink;
      logic     calc_when;
      logic     link;
      logic     snap;
      logic     scan_start;
      logic     scan_step;
      scan_type scan_kind;
      logic     select;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       scan_done;
      logic       out_free;
      logic       cfg_touch;
      logic       arm_req;
      logic       refuse;
      logic       proc_done;
   } stat_type;

endpackage

### src/smts_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted multi-timer scheduler controller
// Sequences configure, expiry processing and wait queries over the datapath.
// ----------------------------------------------------------------------------
module smts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  smts_pkg::stat_type stat,
   output smts_pkg::cmd_type  cmd
);
   import smts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.op)
               OP_CONFIGURE: begin
                  state_in = ST_CFG_UPD;
               end
               OP_PROCESS: begin
                  cmd.snap       = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_DUE_SCAN;
               end
               OP_QUERY: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_QUERY_SCAN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_CFG_UPD: begin
            cmd.cfg_update = 1'b1;
            state_in       = stat.cfg_touch ? ST_UNLINK : ST_EMIT;
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = stat.arm_req ? ST_WHEN : ST_EMIT;
         end
         ST_WHEN: begin
            cmd.calc_when  = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = stat.refuse ? ST_EMIT : ST_LINK_SCAN;
         end
         ST_LINK_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_kind = SCAN_POS;
            if (stat.scan_done) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_EMIT;
         end
         ST_DUE_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_kind = SCAN_DUE;
            if (stat.scan_done) begin
               state_in = stat.proc_done ? ST_EMIT : ST_SELECT;
            end
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_UNLINK;
         end
         ST_QUERY_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_kind = SCAN_HEAD;
            if (stat.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.op == OP_PROCESS && !stat.proc_done) begin
                  state_in = ST_SELECT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/smts_dp.sv
// ----------------------------------------------------------------------------
// Sorted multi-timer scheduler datapath
// Timer state, expiry memory with slot scan, rank updates and result register.
// ----------------------------------------------------------------------------
`include "sorted_multi_timer_scheduler_unit_assert.svh"

module smts_dp (
   input  logic              clock,
   input  logic              reset,
   input  smts_pkg::req_type req_data,
   input  smts_pkg::cmd_type cmd,
   output smts_pkg::stat_type stat,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output smts_pkg::rsp_type rsp_data
);
   import smts_pkg::*;

   req_type                item_ff, item_in;
   logic [IVAL_W-1:0]      period_ff [TIMER_COUNT];
   logic [IVAL_W-1:0]      period_in [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] periodic_ff, periodic_in;
   logic [TIMER_COUNT-1:0] armed_ff, armed_in;
   logic [RANK_W-1:0]      rank_ff [TIMER_COUNT];
   logic [RANK_W-1:0]      rank_in [TIMER_COUNT];
   logic [RANK_W-1:0]      snap_ff [TIMER_COUNT];
   logic [RANK_W-1:0]      snap_in [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] due_ff, due_in;
   logic [RANK_W-1:0]      tgt_ff, tgt_in;
   logic [TIME_BITS-1:0]   when_ff, when_in;
   logic                   refuse_ff, refuse_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [RANK_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [TIME_BITS-1:0]   rd_data_ff;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]       r_ff, r_in;
   logic                   head_vld_ff, head_vld_in;
   logic [TIME_BITS-1:0]   head_exp_ff, head_exp_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [TIME_BITS-1:0]   expiry_mem [TIMER_COUNT];

   logic                   is_cfg;
   logic                   id_ok;
   logic [IVAL_W-1:0]      delay;
   logic [RANK_W-1:0]      tgt_rank;
   logic [TIMER_COUNT-1:0] sel_hit;
   logic [TIMER_COUNT-1:0] head_vec;
   logic [RANK_W-1:0]      sel_idx;
   logic [TIME_BITS-1:0]   wait_diff;
   logic [IVAL_W-1:0]      wait_val;

   assign is_cfg   = item_ff.op == OP_CONFIGURE;
   assign id_ok    = int'(item_ff.timer_id) < TIMER_COUNT;
   assign delay    = (is_cfg && item_ff.first_delay != '0) ? item_ff.first_delay
                                                           : period_ff[tgt_ff];
   assign tgt_rank = rank_ff[tgt_ff];

   always_comb begin
      sel_idx = '0;
      for (int j = 0; j < TIMER_COUNT; j++) begin
         sel_hit[j]  = due_ff[j] && (snap_ff[j] == r_ff[RANK_W-1:0]);
         head_vec[j] = armed_ff[j] && (rank_ff[j] == '0);
         if (sel_hit[j]) begin
            sel_idx = RANK_W'(j);
         end
      end
   end

   assign wait_diff = head_exp_ff - item_ff.now;
   assign wait_val  = (|wait_diff[TIME_BITS-1:IVAL_W]) ? '1 : wait_diff[IVAL_W-1:0];

   assign stat.op        = item_ff.op;
   assign stat.scan_done = (idx_ff == CNT_W'(TIMER_COUNT)) && !rd_vld_ff;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.cfg_touch = id_ok && (item_ff.enable_code == EN_ARM ||
                                     item_ff.enable_code == EN_DISARM);
   assign stat.arm_req   = is_cfg ? (item_ff.enable_code == EN_ARM) : periodic_ff[tgt_ff];
   assign stat.refuse    = delay == '0;
   assign stat.proc_done = r_ff == k_ff;

   // result word for the current item
   always_comb begin
      rsp_in      = '0;
      rsp_in.last = 1'b1;
      case (item_ff.op)
         OP_CONFIGURE: begin
            rsp_in.kind   = KIND_CONFIG;
            rsp_in.status = refuse_ff;
         end
         OP_PROCESS: begin
            rsp_in.kind = KIND_EXPIRY;
            if (k_ff != '0) begin
               rsp_in.fired_id = ID_W'(tgt_ff);
               rsp_in.fired    = 1'b1;
               rsp_in.last     = r_ff == k_ff;
            end
         end
         OP_QUERY: begin
            rsp_in.kind       = KIND_WAIT;
            rsp_in.wait_valid = head_vld_ff;
            if (head_vld_ff && head_exp_ff > item_ff.now) begin
               rsp_in.wait_ms = wait_val;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      period_in    = period_ff;
      periodic_in  = periodic_ff;
      armed_in     = armed_ff;
      rank_in      = rank_ff;
      snap_in      = snap_ff;
      due_in       = due_ff;
      tgt_in       = tgt_ff;
      when_in      = when_ff;
      refuse_in    = refuse_ff;
      idx_in       = idx_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = rd_vld_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      head_vld_in  = head_vld_ff;
      head_exp_in  = head_exp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load) begin
         item_in   = req_data;
         tgt_in    = RANK_W'(req_data.timer_id);
         refuse_in = 1'b0;
         r_in      = '0;
      end

      if (cmd.cfg_update && id_ok) begin
         if (item_ff.repeat_code == RP_PERIODIC) begin
            periodic_in[tgt_ff] = 1'b1;
         end else if (item_ff.repeat_code == RP_ONESHOT) begin
            periodic_in[tgt_ff] = 1'b0;
         end
         if (item_ff.interval != '0) begin
            period_in[tgt_ff] = item_ff.interval;
         end
      end

      if (cmd.unlink && armed_ff[tgt_ff]) begin
         for (int j = 0; j < TIMER_COUNT; j++) begin
            if (armed_ff[j] && rank_ff[j] > tgt_rank) begin
               rank_in[j] = rank_ff[j] - 1'b1;
            end
         end
         armed_in[tgt_ff] = 1'b0;
      end

      if (cmd.calc_when) begin
         when_in   = item_ff.now + TIME_BITS'(delay);
         refuse_in = delay == '0;
      end

      if (cmd.link) begin
         for (int j = 0; j < TIMER_COUNT; j++) begin
            if (armed_ff[j] && {1'b0, rank_ff[j]} >= pos_ff) begin
               rank_in[j] = rank_ff[j] + 1'b1;
            end
         end
         rank_in[tgt_ff]  = pos_ff[RANK_W-1:0];
         armed_in[tgt_ff] = 1'b1;
      end

      // due set and count live across the re-arm scans of one process item
      if (cmd.snap) begin
         snap_in = rank_ff;
         k_in    = '0;
         due_in  = '0;
      end

      if (cmd.scan_start) begin
         idx_in      = '0;
         rd_vld_in   = 1'b0;
         pos_in      = '0;
         head_vld_in = 1'b0;
      end

      if (cmd.scan_step) begin
         if (idx_ff != CNT_W'(TIMER_COUNT)) begin
            rd_idx_in = idx_ff[RANK_W-1:0];
            rd_vld_in = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end else begin
            rd_vld_in = 1'b0;
         end
         if (rd_vld_ff && armed_ff[rd_idx_ff]) begin
            case (cmd.scan_kind)
               SCAN_DUE: begin
                  if (rd_data_ff <= item_ff.now) begin
                     due_in[rd_idx_ff] = 1'b1;
                     k_in              = k_ff + 1'b1;
                  end
               end
               SCAN_POS: begin
                  if (rd_data_ff <= when_ff) begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
               SCAN_HEAD: begin
                  if (rank_ff[rd_idx_ff] == '0) begin
                     head_vld_in = 1'b1;
                     head_exp_in = rd_data_ff;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.select) begin
         tgt_in = sel_idx;
         r_in   = r_ff + 1'b1;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff  <= '0;
         armed_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < TIMER_COUNT; j++) begin
            period_ff[j] <= '0;
         end
      end else begin
         periodic_ff  <= periodic_in;
         armed_ff     <= armed_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rank_ff     <= rank_in;
      snap_ff     <= snap_in;
      due_ff      <= due_in;
      tgt_ff      <= tgt_in;
      when_ff     <= when_in;
      refuse_ff   <= refuse_in;
      rd_idx_ff   <= rd_idx_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      r_ff        <= r_in;
      head_vld_ff <= head_vld_in;
      head_exp_ff <= head_exp_in;
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // expiry store, one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.link) begin
         expiry_mem[tgt_ff] <= when_ff;
      end
      if (cmd.scan_step) begin
         rd_data_ff <= expiry_mem[idx_ff[RANK_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SMTS_ASSERT_IMM(a_link_target_free, clock, reset, cmd.link, !armed_ff[tgt_ff])
   `SMTS_ASSERT_IMM(a_select_onehot, clock, reset, cmd.select, $onehot(sel_hit))
   `SMTS_ASSERT_IMM(a_head_unique, clock, reset, 1'b1, $onehot0(head_vec))
   `SMTS_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff)

endmodule

### src/sorted_multi_timer_scheduler_unit.sv
// Configure: disarming unlinks the timer; arming computes the expiry, then scans the slots
// for the rank position and links it, unless arming is refused. Query: a slot scan for the head.
// Process: a due scan, then each fired timer is selected and unlinked; periodic ones are re-armed
// with a position scan. A result stall holds the unit in its emit state.
// One item at a time; the next item is taken the cycle after the last result is registered.
// Synchronous active-high reset disarms all timers and clears periods and repeat flags.
// ----------------------------------------------------------------------------
// Sorted multi-timer scheduler unit
// Bank of one-shot and periodic timers kept in expiry rank order.
// ----------------------------------------------------------------------------
module sorted_multi_timer_scheduler_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smts_pkg::rsp_type rsp_data
);
   import smts_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   smts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   smts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
